[rtl/gkde_pkg.sv]
// ----------------------------------------------------------------------------
// gkde_pkg
// Shared types, constants and table builders for the kernel density block.
// ----------------------------------------------------------------------------
package gkde_pkg;

	localparam int DIMS            = 4;
	localparam int COUNT_BITS      = 24;
	localparam int EXP_TABLE_DEPTH = 1024;

	localparam int COORD_W = 16;
	localparam int ACC_W   = 48;
	localparam int HALF_W  = ACC_W / 2;
	localparam int KERN_W  = 24;
	localparam int MAG_W   = 33;
	localparam int SQ_W    = 38;
	localparam int SUM_W   = SQ_W + 2;
	localparam int S_W     = 37;
	localparam int IDX_W   = $clog2(EXP_TABLE_DEPTH);
	localparam int POS_W   = S_W + IDX_W;
	localparam int BANK_D  = (EXP_TABLE_DEPTH + 1) / 2;
	localparam int BANK_AW = $clog2(BANK_D);
	localparam int SCALE_W = 32;
	localparam int DENS_W  = 32;
	localparam int SEEN_W  = 24;
	localparam int QCNT_W  = $clog2(ACC_W);
	localparam int CFG_IDX_W = 3;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(EXP_TABLE_DEPTH - 1);

	// 1/(2*pi)^(d/2), unsigned Q0.16
	localparam logic [15:0] NORM_TABLE [4] = '{16'd26145, 16'd10430, 16'd4161, 16'd1660};
	localparam logic [15:0] NORM_Q16 = NORM_TABLE[(DIMS - 1) % 4];

	// Register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_QUERY_X0     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_QUERY_X1     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_QUERY_X2     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_QUERY_X3     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INV_BW       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DENSITY_SCALE = 3'd5;

	typedef enum logic [2:0] {
		FIN_IDLE,
		FIN_DIV,
		FIN_MUL_LO,
		FIN_MUL_HI,
		FIN_OUT
	} fin_state_t;

	typedef struct packed {
		logic            far;
		logic [SQ_W-1:0] sq;
	} lane_t;

	typedef struct packed {
		logic             zero;
		logic [IDX_W-1:0] idx;
		logic [15:0]      frac;
	} pos_t;

	typedef struct packed {
		logic                  valid;
		logic [ACC_W-1:0]      acc;
		logic [COUNT_BITS-1:0] cnt;
		logic                  sat;
	} fin_t;

	typedef logic [15:0] bank_t [BANK_D];

	// exp(-16k/D) in Q0.16: Taylor series for exp(-k/D) in Q30, then four squarings
	function automatic logic [15:0] exp_entry(int k);
		logic [63:0] x;
		logic [63:0] term;
		logic [63:0] v;
		longint      sum;
		if (k >= EXP_TABLE_DEPTH) begin
			return 16'd0;
		end
		x    = (64'(k) << 30) / EXP_TABLE_DEPTH;
		term = 64'd1 << 30;
		sum  = longint'(64'd1 << 30);
		term = ((term * x) >> 30) / 1;  sum = sum - longint'(term);
		term = ((term * x) >> 30) / 2;  sum = sum + longint'(term);
		term = ((term * x) >> 30) / 3;  sum = sum - longint'(term);
		term = ((term * x) >> 30) / 4;  sum = sum + longint'(term);
		term = ((term * x) >> 30) / 5;  sum = sum - longint'(term);
		term = ((term * x) >> 30) / 6;  sum = sum + longint'(term);
		term = ((term * x) >> 30) / 7;  sum = sum - longint'(term);
		term = ((term * x) >> 30) / 8;  sum = sum + longint'(term);
		term = ((term * x) >> 30) / 9;  sum = sum - longint'(term);
		term = ((term * x) >> 30) / 10; sum = sum + longint'(term);
		term = ((term * x) >> 30) / 11; sum = sum - longint'(term);
		term = ((term * x) >> 30) / 12; sum = sum + longint'(term);
		term = ((term * x) >> 30) / 13; sum = sum - longint'(term);
		term = ((term * x) >> 30) / 14; sum = sum + longint'(term);
		term = ((term * x) >> 30) / 15; sum = sum - longint'(term);
		term = ((term * x) >> 30) / 16; sum = sum + longint'(term);
		if (sum < 0) begin
			sum = 0;
		end
		if (sum > longint'(64'd1 << 30)) begin
			sum = longint'(64'd1 << 30);
		end
		v = 64'(sum);
		for (int i = 0; i < 4; i++) begin
			v = (v * v) >> 30;
		end
		v = (v + (64'd1 << 13)) >> 14;
		if (v > 64'hFFFF) begin
			v = 64'hFFFF;
		end
		return v[15:0];
	endfunction

	function automatic bank_t build_bank(int parity);
		bank_t b;
		for (int i = 0; i < BANK_D; i++) begin
			b[i] = exp_entry(2 * i + parity);
		end
		return b;
	endfunction

endpackage

[rtl/gaussian_kde_point_eval_top.sv]
// ----------------------------------------------------------------------------
// gaussian_kde_point_eval_top
// Gaussian kernel density estimate at a configured query point.
// ----------------------------------------------------------------------------
// Points enter one per cycle while a data set streams; each point passes a
// seven-stage pipeline (four coordinate lanes, a merge and table position
// stage, a banked exp table read, interpolation and normalization) into the
// accumulator. After the point flagged by s_tlast the input stalls until the
// result is formed: the pipeline drains, the one-bit-per-cycle mean divider
// runs and the density is scaled. The result register lets the next set
// stream in while the density still waits on the output.
module gaussian_kde_point_eval_top
	import gkde_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [63:0]          s_tdata,  // coord_0, coord_1, coord_2, coord_3
	input  logic                 s_tlast,  // last_point
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [63:0]          m_tdata   // density, points_seen, overflowed
);

	logic [COORD_W-1:0] query_q [4];
	logic [15:0]        inv_bw_q;
	logic [SCALE_W-1:0] scale_q;
	logic               hold_q;

	logic [6:0] vld_s;
	logic [6:0] lst_s;
	logic       accept;
	lane_t      lanes [DIMS];
	pos_t       pos;
	logic [KERN_W-1:0] kern;
	fin_t       fin;
	logic       done;

	assign s_tready = !hold_q;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				query_q[i] <= '0;
			end
			inv_bw_q <= 16'd256;
			scale_q  <= 32'd65536;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_QUERY_X0:      query_q[0] <= cfg_data[15:0];
				REG_QUERY_X1:      query_q[1] <= cfg_data[15:0];
				REG_QUERY_X2:      query_q[2] <= cfg_data[15:0];
				REG_QUERY_X3:      query_q[3] <= cfg_data[15:0];
				REG_INV_BW:        inv_bw_q   <= cfg_data[15:0];
				REG_DENSITY_SCALE: scale_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// stall input from the last point until its result is registered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= 1'b0;
			vld_s  <= '0;
			lst_s  <= '0;
		end else begin
			if (accept && s_tlast) begin
				hold_q <= 1'b1;
			end else if (done) begin
				hold_q <= 1'b0;
			end
			vld_s <= {vld_s[5:0], accept};
			lst_s <= {lst_s[5:0], s_tlast};
		end
	end

	for (genvar g = 0; g < DIMS; g++) begin : g_lane
		gkde_lane u_lane (
			.clk    (clk),
			.coord  (s_tdata[g*COORD_W +: COORD_W]),
			.query  (query_q[g]),
			.inv_bw (inv_bw_q),
			.lane   (lanes[g])
		);
	end

	gkde_merge u_merge (
		.clk   (clk),
		.lanes (lanes),
		.pos   (pos)
	);

	gkde_kernel u_kernel (
		.clk  (clk),
		.pos  (pos),
		.kern (kern)
	);

	gkde_accum u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.vld    (vld_s[6]),
		.last   (lst_s[6]),
		.kern   (kern),
		.fin    (fin)
	);

	gkde_finish u_finish (
		.clk      (clk),
		.arst_n   (arst_n),
		.fin      (fin),
		.scale    (scale_q),
		.done     (done),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

[rtl/gkde_lane.sv]
// ----------------------------------------------------------------------------
// gkde_lane
// One coordinate lane: scaled distance to the query and its square.
// ----------------------------------------------------------------------------
module gkde_lane
	import gkde_pkg::*;
(
	input  logic               clk,
	input  logic [COORD_W-1:0] coord,
	input  logic [COORD_W-1:0] query,
	input  logic [15:0]        inv_bw,
	output lane_t              lane
);

	logic signed [16:0]    diff;
	logic signed [33:0]    prod;
	logic [MAG_W-1:0]      mag;
	logic [MAG_W-1:0]      mag_s1;
	lane_t                 lane_s2;

	assign diff = 17'(signed'(coord)) - 17'(signed'(query));
	assign prod = 34'(diff) * 34'(signed'({1'b0, inv_bw}));
	assign mag  = prod[33] ? MAG_W'(-prod) : MAG_W'(prod);

	always_ff @(posedge clk) begin
		mag_s1      <= mag;
		// far once |u| reaches 8.0 (Q16.16)
		lane_s2.far <= |mag_s1[MAG_W-1:19];
		lane_s2.sq  <= SQ_W'(mag_s1[18:0]) * SQ_W'(mag_s1[18:0]);
	end

	assign lane = lane_s2;

endmodule

[rtl/gkde_merge.sv]
// ----------------------------------------------------------------------------
// gkde_merge
// Sums the lane squares and maps the distance to a table position.
// ----------------------------------------------------------------------------
module gkde_merge
	import gkde_pkg::*;
(
	input  logic  clk,
	input  lane_t lanes [DIMS],
	output pos_t  pos
);

	logic [SUM_W-1:0] sum;
	logic             far_any;
	logic [SUM_W-1:0] sum_s3;
	logic             far_s3;
	logic [POS_W-1:0] prod;
	pos_t             pos_s4;

	always_comb begin
		sum     = '0;
		far_any = 1'b0;
		for (int i = 0; i < DIMS; i++) begin
			sum     = sum + SUM_W'(lanes[i].sq);
			far_any = far_any | lanes[i].far;
		end
	end

	assign prod = POS_W'(sum_s3[S_W-1:0]) * POS_W'(EXP_TABLE_DEPTH);

	always_ff @(posedge clk) begin
		sum_s3      <= sum;
		far_s3      <= far_any;
		// zero kernel past s = 32.0
		pos_s4.zero <= far_s3 | (|sum_s3[SUM_W-1:S_W]);
		pos_s4.idx  <= prod[POS_W-1:S_W];
		pos_s4.frac <= prod[S_W-1:S_W-16];
	end

	assign pos = pos_s4;

endmodule

[rtl/gkde_kernel.sv]
// ----------------------------------------------------------------------------
// gkde_kernel
// Exp table in two banks, linear interpolation and normalization.
// ----------------------------------------------------------------------------
module gkde_kernel
	import gkde_pkg::*;
(
	input  logic              clk,
	input  pos_t              pos,
	output logic [KERN_W-1:0] kern
);

	localparam bank_t EVEN_ROM = build_bank(0);
	localparam bank_t ODD_ROM  = build_bank(1);

	logic [IDX_W-1:0]   half_idx;
	logic [IDX_W-1:0]   even_up;
	logic               tail;
	logic [BANK_AW-1:0] even_addr;
	logic [BANK_AW-1:0] odd_addr;

	logic [15:0] even_s5;
	logic [15:0] odd_s5;
	logic        is_odd_s5;
	logic        tail_s5;
	logic        zero_s5;
	logic [15:0] frac_s5;

	logic [15:0] t0;
	logic [15:0] t1;
	logic [33:0] mix;
	logic [15:0] v_s6;
	logic        zero_s6;
	logic [31:0] scaled;
	logic [KERN_W-1:0] kern_s7;

	assign half_idx  = pos.idx >> 1;
	assign even_up   = half_idx + IDX_W'(pos.idx[0]);
	assign tail      = (pos.idx == LAST_IDX);
	// the entry past the end reads as zero, so park the bank address
	assign even_addr = tail ? '0 : BANK_AW'(even_up);
	assign odd_addr  = BANK_AW'(half_idx);

	always_ff @(posedge clk) begin
		even_s5   <= EVEN_ROM[even_addr];
		odd_s5    <= ODD_ROM[odd_addr];
		is_odd_s5 <= pos.idx[0];
		tail_s5   <= tail;
		zero_s5   <= pos.zero;
		frac_s5   <= pos.frac;
	end

	assign t0  = is_odd_s5 ? odd_s5 : even_s5;
	assign t1  = tail_s5 ? 16'd0 : (is_odd_s5 ? even_s5 : odd_s5);
	assign mix = 34'(t0) * 34'(17'h10000 - 17'(frac_s5)) + 34'(t1) * 34'(frac_s5);

	always_ff @(posedge clk) begin
		v_s6    <= mix[31:16];
		zero_s6 <= zero_s5;
	end

	assign scaled = 32'(v_s6) * 32'(NORM_Q16);

	always_ff @(posedge clk) begin
		kern_s7 <= zero_s6 ? '0 : scaled[KERN_W+7:8];
	end

	assign kern = kern_s7;

endmodule

[rtl/gkde_accum.sv]
// ----------------------------------------------------------------------------
// gkde_accum
// Saturating kernel accumulator and point counter for one data set.
// ----------------------------------------------------------------------------
module gkde_accum
	import gkde_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              vld,
	input  logic              last,
	input  logic [KERN_W-1:0] kern,
	output fin_t              fin
);

	logic [ACC_W-1:0]      acc_q;
	logic [COUNT_BITS-1:0] cnt_q;
	logic                  sat_q;

	logic [ACC_W:0]        sum;
	logic [ACC_W-1:0]      acc_next;
	logic [COUNT_BITS-1:0] cnt_next;
	logic                  sat_next;

	always_comb begin
		sum      = (ACC_W+1)'(acc_q) + (ACC_W+1)'(kern);
		acc_next = sum[ACC_W] ? '1 : sum[ACC_W-1:0];
		cnt_next = (cnt_q == '1) ? cnt_q : cnt_q + 1'b1;
		sat_next = sat_q | sum[ACC_W] | (cnt_q == '1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			cnt_q <= '0;
			sat_q <= 1'b0;
		end else if (vld) begin
			if (last) begin
				acc_q <= '0;
				cnt_q <= '0;
				sat_q <= 1'b0;
			end else begin
				acc_q <= acc_next;
				cnt_q <= cnt_next;
				sat_q <= sat_next;
			end
		end
	end

	assign fin.valid = vld & last;
	assign fin.acc   = acc_next;
	assign fin.cnt   = cnt_next;
	assign fin.sat   = sat_next;

endmodule

[rtl/gkde_finish.sv]
// ----------------------------------------------------------------------------
// gkde_finish
// Mean by shift-subtract division, density scaling and result register.
// ----------------------------------------------------------------------------
module gkde_finish
	import gkde_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  fin_t               fin,
	input  logic [SCALE_W-1:0] scale,
	output logic               done,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [63:0]        m_tdata  // density[31:0], points_seen[55:32], overflowed[56]
);

	fin_state_t state_q;
	fin_state_t state_next;

	logic [ACC_W-1:0]      quot_q;
	logic [COUNT_BITS:0]   rem_q;
	logic [COUNT_BITS-1:0] cnt_q;
	logic                  sat_q;
	logic [QCNT_W-1:0]     step_q;
	logic [HALF_W+SCALE_W-1:0] lo_q;
	logic [HALF_W+SCALE_W-1:0] hi_q;
	logic                  out_vld_q;
	logic [63:0]           out_data_q;

	logic [COUNT_BITS:0]   trial;
	logic                  fits;
	logic [HALF_W+SCALE_W:0] dens_full;
	logic                  dens_ovf;
	logic [DENS_W-1:0]     dens;
	logic [SEEN_W-1:0]     seen;
	logic                  load_out;

	assign trial = {rem_q[COUNT_BITS-1:0], quot_q[ACC_W-1]};
	assign fits  = trial >= (COUNT_BITS+1)'(cnt_q);

	assign dens_full = (HALF_W+SCALE_W+1)'(hi_q) + (HALF_W+SCALE_W+1)'(lo_q >> HALF_W);
	assign dens_ovf  = |dens_full[HALF_W+SCALE_W:DENS_W];
	assign dens      = dens_ovf ? '1 : dens_full[DENS_W-1:0];
	assign seen      = (64'(cnt_q) > 64'({SEEN_W{1'b1}})) ? '1 : SEEN_W'(cnt_q);

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			FIN_IDLE:   if (fin.valid) state_next = FIN_DIV;
			FIN_DIV:    if (step_q == '0) state_next = FIN_MUL_LO;
			FIN_MUL_LO: state_next = FIN_MUL_HI;
			FIN_MUL_HI: state_next = FIN_OUT;
			FIN_OUT:    if (!out_vld_q || m_tready) state_next = FIN_IDLE;
			default:    state_next = FIN_IDLE;
		endcase
	end

	always_comb begin
		load_out = 1'b0;
		unique case (state_q)
			FIN_OUT: load_out = !out_vld_q || m_tready;
			default: load_out = 1'b0;
		endcase
	end

	assign done = load_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= FIN_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (load_out) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			FIN_IDLE: begin
				quot_q <= fin.acc;
				rem_q  <= '0;
				cnt_q  <= fin.cnt;
				sat_q  <= fin.sat;
				step_q <= QCNT_W'(ACC_W - 1);
			end
			FIN_DIV: begin
				// shift in next dividend bit, keep quotient bit in its place
				rem_q  <= fits ? trial - (COUNT_BITS+1)'(cnt_q) : trial;
				quot_q <= {quot_q[ACC_W-2:0], fits};
				step_q <= step_q - 1'b1;
			end
			FIN_MUL_LO: lo_q <= (HALF_W+SCALE_W)'(quot_q[HALF_W-1:0]) * (HALF_W+SCALE_W)'(scale);
			FIN_MUL_HI: hi_q <= (HALF_W+SCALE_W)'(quot_q[ACC_W-1:HALF_W]) * (HALF_W+SCALE_W)'(scale);
			default: ;
		endcase
		if (load_out) begin
			out_data_q <= {7'd0, sat_q | dens_ovf, seen, dens};
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Gaussian kernel density block: data sets of
// points stream through the input port under several query, bandwidth and
// scale settings, and every density word on the output is checked against
// an in-bench fixed-point estimator.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import gkde_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd6;
	localparam int LIMIT = 600000;
	localparam int DRAIN = 80;
	localparam int PHASES = 12;

	typedef struct packed {
		logic [3:0][15:0] c;
		logic             last;
	} point_t;

	typedef struct packed {
		logic [31:0] dens;
		logic [23:0] seen;
		logic        ovf;
	} dens_word_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0]          cfg_data;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [63:0]          s_tdata;
	logic                 s_tlast;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [63:0]          m_tdata;

	gaussian_kde_point_eval_top u_top (.*);

	// estimator state
	logic signed [15:0] q_pt [4];
	logic [15:0]        inv_bw;
	logic [31:0]        d_scale;
	logic [47:0]        kern_sum;
	logic [23:0]        pt_count;
	logic               sat_seen;
	logic [15:0]        exp_lut [EXP_TABLE_DEPTH];

	point_t     pending [$];
	dens_word_t dens_due [$];
	int         errors;
	int         cycles;
	bit         quiet;
	bit         idle_on;
	bit         hold_req;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic void load_exp_lut();
		logic [63:0] x, term, v;
		longint      acc;
		for (int k = 0; k < EXP_TABLE_DEPTH; k++) begin
			x = (64'(k) << 30) / EXP_TABLE_DEPTH;
			term = 64'd1 << 30;
			acc = longint'(term);
			for (int n = 1; n <= 16; n++) begin
				term = ((term * x) >> 30) / n;
				acc = (n % 2) ? acc - longint'(term) : acc + longint'(term);
			end
			if (acc < 0) acc = 0;
			if (acc > (longint'(1) << 30)) acc = longint'(1) << 30;
			v = 64'(acc);
			repeat (4) v = (v * v) >> 30;
			v = (v + (64'd1 << 13)) >> 14;
			exp_lut[k] = (v > 64'hFFFF) ? 16'hFFFF : v[15:0];
		end
	endfunction

	function automatic logic [23:0] kernel_of(point_t p);
		logic [63:0] s, mag, pos, idx, f, t0, t1, v;
		longint      u;
		s = 0;
		for (int i = 0; i < DIMS; i++) begin
			u = (longint'($signed(p.c[i])) - longint'(q_pt[i])) * longint'({1'b0, inv_bw});
			mag = (u < 0) ? 64'(-u) : 64'(u);
			if (mag >= (64'd8 << 16)) return 24'd0;
			s += mag * mag;
		end
		if (s >= (64'd32 << 32)) return 24'd0;
		pos = (s * EXP_TABLE_DEPTH) >> 5;
		idx = pos >> 32;
		if (idx >= EXP_TABLE_DEPTH) return 24'd0;
		f  = (pos >> 16) & 64'hFFFF;
		t0 = exp_lut[idx];
		t1 = (idx + 1 < EXP_TABLE_DEPTH) ? exp_lut[idx + 1] : 64'd0;
		v  = (t0 * (64'd65536 - f) + t1 * f) >> 16;
		return 24'((v * NORM_Q16) >> 8);
	endfunction

	function automatic void accumulate_point(point_t p);
		logic [48:0] nsum;
		logic [47:0] mean;
		logic [79:0] prod;
		dens_word_t  w;
		nsum = {1'b0, kern_sum} + 49'(kernel_of(p));
		if (nsum[48]) begin
			kern_sum = '1;
			sat_seen = 1'b1;
		end else begin
			kern_sum = nsum[47:0];
		end
		if (&pt_count) sat_seen = 1'b1;
		else pt_count++;
		if (!p.last) return;
		mean = (pt_count != 0) ? kern_sum / 48'(pt_count) : 48'd0;
		prod = (80'(mean) * 80'(d_scale)) >> 24;
		if (prod > 80'hFFFF_FFFF) begin
			w.dens = '1;
			sat_seen = 1'b1;
		end else begin
			w.dens = prod[31:0];
		end
		w.seen = pt_count;
		w.ovf = sat_seen;
		dens_due = {dens_due, w};
		kern_sum = 0;
		pt_count = 0;
		sat_seen = 0;
	endfunction

	// driver
	point_t cur;
	int     gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tlast <= 1'b0;
			gap = 0;
		end else begin
			if (s_tvalid && s_tready) accumulate_point(cur);
			if (!s_tvalid || s_tready) begin
				if (gap > 0) begin
					gap--;
					s_tvalid <= 1'b0;
				end else if (pending.size() > 0) begin
					cur = pending.pop_front();
					s_tdata <= cur.c;
					s_tlast <= cur.last;
					s_tvalid <= 1'b1;
					if (!quiet && idle_on && $urandom_range(0, 4) == 0)
						gap = $urandom_range(1, 7);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor
	int hold;
	dens_word_t got, want;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.dens = m_tdata[31:0];
				got.seen = m_tdata[55:32];
				got.ovf = m_tdata[56];
				if (dens_due.size() == 0) begin
					$error("density word with nothing due: %h", m_tdata);
					errors++;
				end else begin
					want = dens_due.pop_front();
					if (got.dens !== want.dens) begin
						$error("density: expected %h, got %h", want.dens, got.dens);
						errors++;
					end
					if (got.seen !== want.seen) begin
						$error("points_seen: expected %0d, got %0d", want.seen, got.seen);
						errors++;
					end
					if (got.ovf !== want.ovf) begin
						$error("overflowed: expected %b, got %b", want.ovf, got.ovf);
						errors++;
					end
				end
			end
			if (hold_req) begin
				hold_req = 1'b0;
				hold = 400;
			end
			if (hold > 0) begin
				hold--;
				m_tready <= 1'b0;
			end else if (!quiet && idle_on && $urandom_range(0, 4) == 0) begin
				hold = $urandom_range(0, 6);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("gaussian_kde_point_eval_top: mismatch");
			$finish;
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx < REG_INV_BW) q_pt[idx] = val[15:0];
		else if (idx == REG_INV_BW) inv_bw = val[15:0];
		else if (idx == REG_DENSITY_SCALE) d_scale = val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic point_t make_point(bit last);
		point_t p;
		int     lim, d;
		for (int i = 0; i < 4; i++) begin
			if ($urandom_range(0, 9) < 3 || inv_bw == 0) begin
				p.c[i] = 16'($urandom);
			end else begin
				lim = (1 << 19) / inv_bw;
				if (lim > 32767) lim = 32767;
				d = int'(q_pt[i]) + $urandom_range(0, 2 * lim) - lim;
				if (d > 32767) d = 32767;
				if (d < -32768) d = -32768;
				p.c[i] = d[15:0];
			end
		end
		p.last = last;
		return p;
	endfunction

	task automatic push_set(int n);
		@(negedge clk);
		for (int i = 0; i < n; i++) pending = {pending, make_point(i == n - 1)};
	endtask

	// let the block drain before the next register write
	task automatic settle();
		@(negedge clk);
		while (pending.size() > 0 || s_tvalid || dens_due.size() > 0) @(negedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	point_t     dp;
	int         n, sz;
	logic [15:0] bw_pick [5] = '{16'd0, 16'd1, 16'd256, 16'hFFFF, 16'd64};
	logic [31:0] sc_pick [4] = '{32'd0, 32'hFFFF_FFFF, 32'd65536, 32'd1};

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		errors = 0;
		cycles = 0;
		quiet = 0;
		idle_on = 1;
		hold_req = 0;
		for (int i = 0; i < 4; i++) q_pt[i] = 0;
		inv_bw = 16'd256;
		d_scale = 32'd65536;
		kern_sum = 0;
		pt_count = 0;
		sat_seen = 0;
		load_exp_lut();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: peak, field extremes, far points, single-point sets
		@(negedge clk);
		dp.c = '0; dp.last = 1; pending = {pending, dp};
		dp.c = {4{16'h7FFF}}; dp.last = 0; pending = {pending, dp};
		dp.c = {4{16'h8000}}; dp.last = 1; pending = {pending, dp};
		dp.c = {16'h0000, 16'h0000, 16'h0000, 16'h0800}; dp.last = 0; pending = {pending, dp};
		dp.c = {16'h0000, 16'h0000, 16'h0000, 16'h07FF}; dp.last = 0; pending = {pending, dp};
		dp.c = {16'h0400, 16'h0400, 16'h0300, 16'h0300}; dp.last = 0; pending = {pending, dp};
		dp.c = {16'hFF00, 16'h0100, 16'hFF80, 16'h0080}; dp.last = 1; pending = {pending, dp};
		dp.c = {16'h0000, 16'h8000, 16'h0000, 16'h0000}; dp.last = 1; pending = {pending, dp};
		settle();
		write_reg(REG_INV_BW, 32'd0);
		write_reg(REG_DENSITY_SCALE, 32'hFFFF_FFFF);
		write_reg(REG_SPARE, 32'hFFFF_FFFF);
		@(negedge clk);
		dp.c = {4{16'h8000}}; dp.last = 0; pending = {pending, dp};
		dp.c = {4{16'h7FFF}}; dp.last = 1; pending = {pending, dp};
		settle();
		write_reg(REG_QUERY_X0, 32'h0000_7FFF);
		write_reg(REG_QUERY_X1, 32'h0000_8000);
		write_reg(REG_QUERY_X2, 32'h0000_7FFF);
		write_reg(REG_QUERY_X3, 32'h0000_8000);
		write_reg(REG_INV_BW, 32'hFFFF);
		write_reg(REG_DENSITY_SCALE, 32'd0);
		@(negedge clk);
		dp.c = {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF}; dp.last = 1; pending = {pending, dp};
		settle();
		write_reg(REG_DENSITY_SCALE, 32'hFFFF_FFFF);
		push_set(3);
		settle();

		for (int ph = 0; ph < PHASES; ph++) begin
			for (int i = 0; i < 4; i++)
				write_reg(REG_QUERY_X0 + CFG_IDX_W'(i),
					(ph % 4 == 1) ? {16'h0, (i % 2) ? 16'h8000 : 16'h7FFF} : 32'($urandom));
			write_reg(REG_INV_BW, (ph < 5) ? 32'(bw_pick[ph]) : 32'($urandom_range(16, 2048)));
			write_reg(REG_DENSITY_SCALE, (ph < 4) ? sc_pick[ph] : $urandom);
			quiet = (ph >= PHASES - 2);
			idle_on = (ph % 3 != 2);
			if (ph == 3) begin
				@(negedge clk);
				hold_req = 1'b1;
			end
			n = 0;
			while (n < 125) begin
				sz = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 90) : $urandom_range(1, 12);
				push_set(sz);
				n += sz;
			end
			settle();
		end

		if (dens_due.size() != 0) errors++;
		if (errors == 0) begin
			$display("gaussian_kde_point_eval_top: match");
		end else begin
			$display("gaussian_kde_point_eval_top: mismatch");
		end
		$finish;
	end

endmodule
